### src/salwc_pkg.sv
`timescale 1ns / 1ps

package salwc_pkg;

    // build-time geometry
    localparam int MAX_SET_BITS = 6;
    localparam int WAYS         = 8;
    localparam int ADDR_BITS    = 48;

    localparam int SETS  = 1 << MAX_SET_BITS;
    localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int SB_W  = (MAX_SET_BITS > 0) ? $clog2(MAX_SET_BITS + 1) : 1;
    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int TAG_W = ADDR_BITS;

    // fixed field widths
    localparam int TIME_W         = 32;
    localparam int CNT_W          = 48;
    localparam int MAX_BLOCK_BITS = 32;
    localparam int BYTES_W        = MAX_BLOCK_BITS + 1;
    localparam int SET_CFG_W      = 3;
    localparam int BLOCK_CFG_W    = 6;
    localparam int WAYS_CFG_W     = 4;
    localparam int CFG_DATA_W     = 6;
    localparam int CFG_IDX_W      = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = CFG_IDX_W'(2);

    localparam logic [SET_CFG_W-1:0]   SET_BITS_RST   = SET_CFG_W'(0);
    localparam logic [BLOCK_CFG_W-1:0] BLOCK_BITS_RST = BLOCK_CFG_W'(4);
    localparam logic [WAYS_CFG_W-1:0]  WAYS_RST       = WAYS_CFG_W'(1);

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SPLIT,
        ST_READ,
        ST_SCAN,
        ST_EVICT,
        ST_COMMIT,
        ST_RESP
    } state_t;

    // one set of the cache, all ways side by side
    typedef struct packed {
        logic [WAYS-1:0][TAG_W-1:0]  tag;
        logic [WAYS-1:0][TIME_W-1:0] last_use;
        logic [WAYS-1:0]             valid;
        logic [WAYS-1:0]             dirty;
    } row_t;

    typedef struct packed {
        logic clear;
        logic step;
    } scan_ctl_t;

    typedef struct packed {
        logic             done;
        logic             hit;
        logic             evict;
        logic             way_dirty;
        logic [WAY_W-1:0] way;
    } scan_res_t;

    typedef struct packed {
        logic               evict_step;
        logic               commit_step;
        logic               hit;
        logic               evict;
        logic               dirty_evict;
        logic               add_dirty;
        logic [BYTES_W-1:0] bytes;
    } stats_cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0] hits;
        logic [CNT_W-1:0] misses;
        logic [CNT_W-1:0] evictions;
        logic [CNT_W-1:0] dirty_held;
        logic [CNT_W-1:0] dirty_evicted;
    } stats_t;

endpackage

### src/salwc_if.sv
`timescale 1ns / 1ps

interface salwc_req_if
    import salwc_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 opcode;
    logic [ADDR_BITS-1:0] address;

    modport source (output valid, output opcode, output address, input ready);
    modport sink   (input valid, input opcode, input address, output ready);
endinterface

interface salwc_rsp_if
    import salwc_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             was_hit;
    logic             was_eviction;
    logic             was_dirty_eviction;
    logic [CNT_W-1:0] hits_so_far;
    logic [CNT_W-1:0] misses_so_far;
    logic [CNT_W-1:0] evictions_so_far;
    logic [CNT_W-1:0] dirty_resident_bytes;
    logic [CNT_W-1:0] dirty_evicted_bytes;

    modport source (
        output valid, output was_hit, output was_eviction, output was_dirty_eviction,
        output hits_so_far, output misses_so_far, output evictions_so_far,
        output dirty_resident_bytes, output dirty_evicted_bytes,
        input ready
    );
    modport sink (
        input valid, input was_hit, input was_eviction, input was_dirty_eviction,
        input hits_so_far, input misses_so_far, input evictions_so_far,
        input dirty_resident_bytes, input dirty_evicted_bytes,
        output ready
    );
endinterface

### src/salwc_row_ram.sv
`timescale 1ns / 1ps

module salwc_row_ram
    import salwc_pkg::*;
(
    input  logic             clk,
    input  logic             rd_en,
    input  logic [SET_W-1:0] rd_addr,
    output row_t             rd_data,
    input  logic             wr_en,
    input  logic [SET_W-1:0] wr_addr,
    input  row_t             wr_data
);

    row_t mem [SETS];
    row_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### src/salwc_scan.sv
`timescale 1ns / 1ps

module salwc_scan
    import salwc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  scan_ctl_t        ctl,
    input  row_t             row,
    input  logic [TAG_W-1:0] tag,
    input  logic [WAY_W-1:0] last_way,
    output scan_res_t        res
);

    logic [WAY_W-1:0]  way_reg, way_next;
    logic              hit_reg, hit_next;
    logic              free_reg, free_next;
    logic [WAY_W-1:0]  victim_reg, victim_next;
    logic [TIME_W-1:0] min_reg, min_next;

    logic              cur_valid;
    logic              cur_match;
    logic              cur_older;
    logic [TIME_W-1:0] cur_time;

    // one way per cycle through the shared tag and age comparators
    assign cur_valid = row.valid[way_reg];
    assign cur_time  = row.last_use[way_reg];
    assign cur_match = cur_valid && (row.tag[way_reg] == tag);
    assign cur_older = (way_reg == '0) || (cur_time < min_reg);

    always_comb
    begin
        way_next    = way_reg;
        hit_next    = hit_reg;
        free_next   = free_reg;
        victim_next = victim_reg;
        min_next    = min_reg;
        if (ctl.clear)
        begin
            way_next    = '0;
            hit_next    = 1'b0;
            free_next   = 1'b0;
            victim_next = '0;
        end
        else if (ctl.step)
        begin
            way_next = way_reg + WAY_W'(1);
            if (cur_match)
            begin
                hit_next    = 1'b1;
                victim_next = way_reg;
            end
            else if (!cur_valid && !free_reg)
            begin
                free_next   = 1'b1;
                victim_next = way_reg;
            end
            else if (!free_reg && cur_older)
            begin
                victim_next = way_reg;
                min_next    = cur_time;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            way_reg  <= '0;
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
        end
        else
        begin
            way_reg  <= way_next;
            hit_reg  <= hit_next;
            free_reg <= free_next;
        end
    end

    always_ff @(posedge clk)
    begin
        victim_reg <= victim_next;
        min_reg    <= min_next;
    end

    assign res.done      = ctl.step && (cur_match || (way_reg == last_way));
    assign res.hit       = hit_reg;
    assign res.evict     = !hit_reg && !free_reg;
    assign res.way_dirty = row.dirty[victim_reg];
    assign res.way       = victim_reg;

endmodule

### src/salwc_stats.sv
`timescale 1ns / 1ps

module salwc_stats
    import salwc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  stats_cmd_t cmd,
    output stats_t     stats
);

    stats_t cnt_reg, cnt_next;

    logic [CNT_W-1:0] bytes_ext;

    function automatic logic [CNT_W-1:0] sat_add(
        input logic [CNT_W-1:0] a,
        input logic [CNT_W-1:0] b
    );
        logic [CNT_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
    endfunction

    assign bytes_ext = CNT_W'(cmd.bytes);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.evict_step)
        begin
            if (cmd.evict)
            begin
                cnt_next.evictions = sat_add(cnt_reg.evictions, CNT_W'(1));
            end
            if (cmd.dirty_evict)
            begin
                cnt_next.dirty_evicted = sat_add(cnt_reg.dirty_evicted, bytes_ext);
                cnt_next.dirty_held    = (cnt_reg.dirty_held > bytes_ext) ?
                                         cnt_reg.dirty_held - bytes_ext : '0;
            end
        end
        else if (cmd.commit_step)
        begin
            if (cmd.hit)
            begin
                cnt_next.hits = sat_add(cnt_reg.hits, CNT_W'(1));
            end
            else
            begin
                cnt_next.misses = sat_add(cnt_reg.misses, CNT_W'(1));
            end
            if (cmd.add_dirty)
            begin
                cnt_next.dirty_held = sat_add(cnt_reg.dirty_held, bytes_ext);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    assign stats = cnt_reg;

endmodule

### src/set_assoc_lru_writeback_cache_model.sv
`timescale 1ns / 1ps

// set-associative write-back cache model with lru replacement
// req channel: one load (opcode 0) or store (opcode 1) at a byte address per transfer
// rsp channel: one result per access: hit, eviction and dirty-eviction flags plus the
//   running hit, miss and eviction counts and the dirty resident and dirty evicted bytes
// cfg port: cfg_we with cfg_index 0 set_bits, 1 block_bits, 2 ways_in_use; write only
//   while no access is in flight
// after its req transfer an access goes through the split, read, scan, evict, commit and
//   resp states, and its result shows on rsp from the result register; the way scan stops at
//   the first tag match, else runs over all ways in use; one set row is read from the row
//   ram and the ways go one per cycle through a single tag compare and age compare unit
// req.ready is high only while the sequencer is idle, so one access is in flight at a time
//   and a new access transfers only after the last one has loaded its result register
// the result sits in an output register; the next access can be taken and processed while
//   it waits, and the sequencer holds before overwriting it if rsp stays stalled
// reset: all lines invalid and clean (a per-set live bit masks rows never written), access
//   time 1, counters zero, set_bits 0, block_bits 4, ways_in_use 1; no clearing pass
module set_assoc_lru_writeback_cache_model
    import salwc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    salwc_req_if.sink             req,
    salwc_rsp_if.source           rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    state_t state_reg, state_next;

    // configuration
    logic [SET_CFG_W-1:0]   set_bits_reg;
    logic [BLOCK_CFG_W-1:0] block_bits_reg;
    logic [WAYS_CFG_W-1:0]  ways_reg;

    // access in flight
    logic                 store_reg;
    logic [ADDR_BITS-1:0] addr_reg;
    logic [ADDR_BITS-1:0] shifted_reg;
    logic [SB_W-1:0]      sb_reg;
    logic [SET_W-1:0]     set_reg;
    logic [BYTES_W-1:0]   bytes_reg;
    logic [WAY_W-1:0]     last_way_reg;
    logic [TAG_W-1:0]     tag_reg;
    logic                 live_reg;

    logic [SETS-1:0]   row_live_reg;
    logic [TIME_W-1:0] access_time_reg;

    // result register
    logic             out_valid_reg;
    logic             out_hit_reg;
    logic             out_evict_reg;
    logic             out_dirty_evict_reg;
    stats_t           out_stats_reg;

    // address split
    logic [SB_W-1:0]        sb;
    logic [BLOCK_CFG_W-1:0] bb;
    logic [ADDR_BITS-1:0]   shifted;
    logic [SET_W-1:0]       set_mask;
    logic [WAY_W-1:0]       last_way;

    // sequencer outputs
    logic      ram_rd;
    logic      ram_wr;
    logic      out_load;
    scan_ctl_t scan_ctl;

    row_t       row_q;
    row_t       row_view;
    row_t       row_new;
    scan_res_t  scan_res;
    stats_cmd_t stats_cmd;
    stats_t     stats;

    // ---------------------------------------------------------------
    // configuration writes, out-of-range indexes are dropped
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg   <= SET_BITS_RST;
            block_bits_reg <= BLOCK_BITS_RST;
            ways_reg       <= WAYS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SET_BITS:    set_bits_reg   <= cfg_wdata[SET_CFG_W-1:0];
                CFG_BLOCK_BITS:  block_bits_reg <= cfg_wdata[BLOCK_CFG_W-1:0];
                CFG_WAYS_IN_USE: ways_reg       <= cfg_wdata[WAYS_CFG_W-1:0];
                default:         ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // address split: clamp the fields, then offset shift and set mask
    // ---------------------------------------------------------------
    assign sb = (int'(set_bits_reg) > MAX_SET_BITS) ? SB_W'(MAX_SET_BITS)
                                                     : SB_W'(set_bits_reg);
    assign bb = (int'(block_bits_reg) > MAX_BLOCK_BITS) ? BLOCK_CFG_W'(MAX_BLOCK_BITS)
                                                         : block_bits_reg;
    assign shifted  = addr_reg >> bb;
    assign set_mask = ~({SET_W{1'b1}} << sb);

    // zero ways behaves as one, more than built behaves as all
    always_comb
    begin
        if (ways_reg == '0)
        begin
            last_way = '0;
        end
        else if (int'(ways_reg) > WAYS)
        begin
            last_way = WAY_W'(WAYS - 1);
        end
        else
        begin
            last_way = WAY_W'(ways_reg - WAYS_CFG_W'(1));
        end
    end

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_SPLIT;
                end
            end
            ST_SPLIT:  state_next = ST_READ;
            ST_READ:   state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (scan_res.done)
                begin
                    state_next = ST_EVICT;
                end
            end
            ST_EVICT:  state_next = ST_COMMIT;
            ST_COMMIT: state_next = ST_RESP;
            ST_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        req.ready      = 1'b0;
        ram_rd         = 1'b0;
        ram_wr         = 1'b0;
        out_load       = 1'b0;
        scan_ctl.clear = 1'b0;
        scan_ctl.step  = 1'b0;
        unique case (state_reg)
            ST_IDLE:   req.ready = 1'b1;
            ST_READ:
            begin
                ram_rd         = 1'b1;
                scan_ctl.clear = 1'b1;
            end
            ST_SCAN:   scan_ctl.step = 1'b1;
            ST_COMMIT: ram_wr = 1'b1;
            ST_RESP:   out_load = !out_valid_reg || rsp.ready;
            default:   ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ---------------------------------------------------------------
    // access datapath registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            store_reg <= req.opcode;
            addr_reg  <= req.address;
        end
        if (state_reg == ST_SPLIT)
        begin
            shifted_reg  <= shifted;
            sb_reg       <= sb;
            set_reg      <= shifted[SET_W-1:0] & set_mask;
            bytes_reg    <= BYTES_W'(1) << bb;
            last_way_reg <= last_way;
        end
        if (state_reg == ST_READ)
        begin
            tag_reg  <= shifted_reg >> sb_reg;
            live_reg <= row_live_reg[set_reg];
        end
    end

    // ---------------------------------------------------------------
    // set rows: a row never written reads as all ways invalid and clean
    // ---------------------------------------------------------------
    salwc_row_ram u_row_ram (
        .clk     (clk),
        .rd_en   (ram_rd),
        .rd_addr (set_reg),
        .rd_data (row_q),
        .wr_en   (ram_wr),
        .wr_addr (set_reg),
        .wr_data (row_new)
    );

    always_comb
    begin
        row_view       = row_q;
        row_view.valid = row_q.valid & {WAYS{live_reg}};
        row_view.dirty = row_q.dirty & {WAYS{live_reg}};
    end

    // updated row: refresh on a hit, fill the victim on a miss
    always_comb
    begin
        row_new                        = row_view;
        row_new.last_use[scan_res.way] = access_time_reg;
        if (scan_res.hit)
        begin
            row_new.dirty[scan_res.way] = row_view.dirty[scan_res.way] | store_reg;
        end
        else
        begin
            row_new.valid[scan_res.way] = 1'b1;
            row_new.tag[scan_res.way]   = tag_reg;
            row_new.dirty[scan_res.way] = store_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_live_reg    <= '0;
            access_time_reg <= TIME_W'(1);
        end
        else if (ram_wr)
        begin
            row_live_reg[set_reg] <= 1'b1;
            access_time_reg       <= access_time_reg + TIME_W'(1);
        end
    end

    // ---------------------------------------------------------------
    // way scan: hit search, first free way and lru victim in one pass
    // ---------------------------------------------------------------
    salwc_scan u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (scan_ctl),
        .row      (row_view),
        .tag      (tag_reg),
        .last_way (last_way_reg),
        .res      (scan_res)
    );

    // ---------------------------------------------------------------
    // counters: eviction accounting first, then hit/miss and new dirty bytes
    // ---------------------------------------------------------------
    always_comb
    begin
        stats_cmd.evict_step  = (state_reg == ST_EVICT);
        stats_cmd.commit_step = (state_reg == ST_COMMIT);
        stats_cmd.hit         = scan_res.hit;
        stats_cmd.evict       = scan_res.evict;
        stats_cmd.dirty_evict = scan_res.evict && scan_res.way_dirty;
        stats_cmd.add_dirty   = store_reg && !(scan_res.hit && scan_res.way_dirty);
        stats_cmd.bytes       = bytes_reg;
    end

    salwc_stats u_stats (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (stats_cmd),
        .stats (stats)
    );

    // ---------------------------------------------------------------
    // result register
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_hit_reg         <= scan_res.hit;
            out_evict_reg       <= scan_res.evict;
            out_dirty_evict_reg <= scan_res.evict && scan_res.way_dirty;
            out_stats_reg       <= stats;
        end
    end

    assign rsp.valid                = out_valid_reg;
    assign rsp.was_hit              = out_hit_reg;
    assign rsp.was_eviction         = out_evict_reg;
    assign rsp.was_dirty_eviction   = out_dirty_evict_reg;
    assign rsp.hits_so_far          = out_stats_reg.hits;
    assign rsp.misses_so_far        = out_stats_reg.misses;
    assign rsp.evictions_so_far     = out_stats_reg.evictions;
    assign rsp.dirty_resident_bytes = out_stats_reg.dirty_held;
    assign rsp.dirty_evicted_bytes  = out_stats_reg.dirty_evicted;

endmodule
